### sv/salc_pkg.sv
package salc_pkg;

  localparam int ADDR_W = 16;
  localparam int ROW_OUT_W = 6;
  localparam int COST_W = 9;
  localparam int TOTAL_W = 32;

  localparam logic [1:0] OP_ACCESS = 2'd0;
  localparam logic [1:0] OP_INVALIDATE = 2'd1;
  localparam logic [1:0] OP_CLEAR_TOTAL = 2'd2;

  localparam logic [1:0] REG_BLOCK_LOG2 = 2'd0;
  localparam logic [1:0] REG_ROW_LOG2 = 2'd1;
  localparam logic [1:0] REG_WAYS_IN_USE = 2'd2;
  localparam logic [1:0] REG_MISS_PENALTY = 2'd3;

  localparam logic [2:0] BLOCK_LOG2_RESET = 3'd2;
  localparam logic [2:0] ROW_LOG2_RESET = 3'd0;
  localparam logic [3:0] WAYS_IN_USE_RESET = 4'd2;
  localparam logic [7:0] MISS_PENALTY_RESET = 8'd19;

  localparam logic [2:0] BLOCK_LOG2_MIN = 3'd2;
  localparam logic [2:0] BLOCK_LOG2_MAX = 3'd6;

  typedef struct packed {
    logic [1:0] opcode;
    logic [ADDR_W-1:0] address;
  } req_t;

  typedef struct packed {
    logic hit;
    logic [ROW_OUT_W-1:0] row_index;
    logic [ADDR_W-1:0] tag_value;
    logic [COST_W-1:0] access_cycles;
    logic [TOTAL_W-1:0] cycle_total;
  } rsp_t;

endpackage

### sv/salc_way_update.sv
module salc_way_update import salc_pkg::*; #(
  parameter int MAX_WAYS = 8,
  parameter int TAG_W = 14,
  parameter int WCNT_W = 4
) (
  input  logic [MAX_WAYS-1:0][TAG_W:0] row,
  input  logic [TAG_W-1:0] tag,
  input  logic [WCNT_W-1:0] ways,
  output logic hit,
  output logic [MAX_WAYS-1:0][TAG_W:0] row_next
);

  localparam int WIDX_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

  logic [WIDX_W-1:0] pos;

  // The lowest matching way wins; on a miss the last way in use is replaced.
  always_comb begin
    hit = 1'b0;
    pos = WIDX_W'(ways - WCNT_W'(1));
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if ((32'(i) < 32'(ways)) && row[i][TAG_W] && (row[i][TAG_W-1:0] == tag)) begin
        hit = 1'b1;
        pos = WIDX_W'(i);
      end
    end
  end

  always_comb begin
    row_next[0] = hit ? row[pos] : {1'b1, tag};
    for (int i = 1; i < MAX_WAYS; i++) begin
      row_next[i] = (32'(pos) >= 32'(i)) ? row[i-1] : row[i];
    end
  end

endmodule

### sv/set_assoc_lru_cache_tags_core.sv
// Set-associative cache tag store with true LRU replacement.
// Requests arrive on req (valid/ready) with an opcode and a byte address;
// each request yields exactly one item on rsp (valid/ready) carrying hit,
// row, tag, the access cost and the saturating running cycle total.
// An access reads its row from the tag memory at the edge that accepts it,
// compares all ways in parallel in the next cycle, writes back the reordered
// row and registers the result: the row read register and the result
// register lie between acceptance and a valid result, and no new request is
// taken while the row is being compared and written back.
// An invalidate request sweeps the tag memory one row per cycle; its result
// is registered as the last row is cleared. A clear-total request, or one
// with an unused opcode, has its result registered at the edge that accepts it.
// After reset the same sweep clears every row before the first request is
// taken; configuration writes are accepted throughout. The result register
// holds its item while rsp_ready is low; a new request is taken only when
// that register is free or being emptied in that cycle. The user must write
// configuration (APB byte addresses 0, 4, 8 and 12: block_log2, row_log2,
// ways_in_use, miss_penalty) only while idle; the block does not enforce it.
module set_assoc_lru_cache_tags_core import salc_pkg::*; #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_WAYS = 8,
  parameter int ADDR_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [3:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);

  localparam int EFF_BITS = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
  localparam int TAG_W = EFF_BITS - 2;
  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int ROW_LOG_MAX = $clog2(MAX_ROWS + 1) - 1;
  localparam int WCNT_W = $clog2(MAX_WAYS + 1);
  localparam logic [ADDR_W-1:0] ADDR_MASK = ADDR_W'((33'h1 << EFF_BITS) - 33'h1);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_LOOK} state_t;

  typedef logic [MAX_WAYS-1:0][TAG_W:0] row_t;

  state_t state;
  logic [ROW_W-1:0] clr_cnt;
  logic clr_reply;
  logic [ROW_W-1:0] row_q;
  logic [ROW_OUT_W-1:0] row_out_q;
  logic [ADDR_W-1:0] tag_q;
  logic [TOTAL_W-1:0] total;
  logic rsp_load;

  logic [2:0] block_log2;
  logic [2:0] row_log2;
  logic [3:0] ways_in_use;
  logic [7:0] miss_penalty;

  row_t mem [MAX_ROWS];
  row_t rd_row;
  row_t row_next;
  logic mem_we;
  logic [ROW_W-1:0] mem_waddr;
  row_t mem_wdata;

  logic [2:0] bl_c;
  logic [2:0] rl_c;
  logic [WCNT_W-1:0] ways_c;
  logic [ADDR_W-1:0] addr_eff;
  logic [ADDR_W-1:0] row_full;
  logic [ADDR_W-1:0] tag_full;
  logic hit;
  logic [COST_W-1:0] cost;
  logic [TOTAL_W:0] sum;
  logic [TOTAL_W-1:0] total_next;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_log2 <= BLOCK_LOG2_RESET;
      row_log2 <= ROW_LOG2_RESET;
      ways_in_use <= WAYS_IN_USE_RESET;
      miss_penalty <= MISS_PENALTY_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_BLOCK_LOG2: block_log2 <= pwdata[2:0];
        REG_ROW_LOG2: row_log2 <= pwdata[2:0];
        REG_WAYS_IN_USE: ways_in_use <= pwdata[3:0];
        REG_MISS_PENALTY: miss_penalty <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_BLOCK_LOG2: prdata = 32'(block_log2);
      REG_ROW_LOG2: prdata = 32'(row_log2);
      REG_WAYS_IN_USE: prdata = 32'(ways_in_use);
      REG_MISS_PENALTY: prdata = 32'(miss_penalty);
      default: prdata = '0;
    endcase
  end

  always_comb begin
    if (block_log2 < BLOCK_LOG2_MIN) begin
      bl_c = BLOCK_LOG2_MIN;
    end else if (block_log2 > BLOCK_LOG2_MAX) begin
      bl_c = BLOCK_LOG2_MAX;
    end else begin
      bl_c = block_log2;
    end
    if (32'(row_log2) > ROW_LOG_MAX) begin
      rl_c = 3'(ROW_LOG_MAX);
    end else begin
      rl_c = row_log2;
    end
    if (ways_in_use == 4'd0) begin
      ways_c = WCNT_W'(1);
    end else if (32'(ways_in_use) > MAX_WAYS) begin
      ways_c = WCNT_W'(MAX_WAYS);
    end else begin
      ways_c = WCNT_W'(ways_in_use);
    end
  end

  assign addr_eff = req.address & ADDR_MASK;
  assign row_full = (addr_eff >> bl_c) & ((ADDR_W'(1) << rl_c) - ADDR_W'(1));
  assign tag_full = addr_eff >> ({1'b0, bl_c} + {1'b0, rl_c});

  assign req_ready = (state == S_IDLE) && (!rsp_valid || rsp_ready);

  always_ff @(posedge clk) begin
    rd_row <= mem[row_full[ROW_W-1:0]];
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  salc_way_update #(
    .MAX_WAYS(MAX_WAYS),
    .TAG_W(TAG_W),
    .WCNT_W(WCNT_W)
  ) u_way_update (
    .row(rd_row),
    .tag(tag_q[TAG_W-1:0]),
    .ways(ways_c),
    .hit(hit),
    .row_next(row_next)
  );

  assign mem_we = (state == S_CLEAR) || (state == S_LOOK);
  assign mem_waddr = (state == S_CLEAR) ? clr_cnt : row_q;
  assign mem_wdata = (state == S_CLEAR) ? '0 : row_next;

  assign cost = hit ? COST_W'(1)
                    : COST_W'(1) + COST_W'(miss_penalty) + (COST_W'(1) << bl_c);
  assign sum = {1'b0, total} + (TOTAL_W + 1)'(cost);
  assign total_next = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];

  always_comb begin
    case (state)
      S_CLEAR: rsp_load = clr_reply && (clr_cnt == ROW_W'(MAX_ROWS - 1));
      S_IDLE: rsp_load = req_valid && req_ready && (req.opcode != OP_ACCESS)
                         && (req.opcode != OP_INVALIDATE);
      S_LOOK: rsp_load = 1'b1;
      default: rsp_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_cnt <= '0;
      clr_reply <= 1'b0;
      rsp_valid <= 1'b0;
      total <= '0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (clr_cnt == ROW_W'(MAX_ROWS - 1)) begin
            state <= S_IDLE;
            clr_cnt <= '0;
            if (clr_reply) begin
              clr_reply <= 1'b0;
              rsp <= '{hit: 1'b0, row_index: '0, tag_value: '0,
                       access_cycles: '0, cycle_total: total};
            end
          end else begin
            clr_cnt <= clr_cnt + ROW_W'(1);
          end
        end
        S_IDLE: begin
          if (req_valid && req_ready) begin
            row_q <= row_full[ROW_W-1:0];
            row_out_q <= row_full[ROW_OUT_W-1:0];
            tag_q <= tag_full;
            case (req.opcode)
              OP_ACCESS: begin
                state <= S_LOOK;
              end
              OP_INVALIDATE: begin
                state <= S_CLEAR;
                clr_reply <= 1'b1;
              end
              OP_CLEAR_TOTAL: begin
                total <= '0;
                rsp <= '{hit: 1'b0, row_index: '0, tag_value: '0,
                         access_cycles: '0, cycle_total: '0};
              end
              default: begin
                rsp <= '{hit: 1'b0, row_index: '0, tag_value: '0,
                         access_cycles: '0, cycle_total: total};
              end
            endcase
          end
        end
        S_LOOK: begin
          state <= S_IDLE;
          total <= total_next;
          rsp <= '{hit: hit, row_index: row_out_q, tag_value: tag_q,
                   access_cycles: cost, cycle_total: total_next};
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_hit_cost: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.hit) |-> (rsp.access_cycles == COST_W'(1)))
    else $error("hit result with cost other than one");

  a_total_covers_cost: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.cycle_total >= TOTAL_W'(rsp.access_cycles)))
    else $error("cycle total below the cost of the item");

  a_look_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOOK) |=> (rsp_valid && (state == S_IDLE)))
    else $error("access did not produce a result");

  a_no_req_while_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR || state == S_LOOK) |-> !req_ready)
    else $error("request taken while a row is being written");
`endif

endmodule

### test/testbench.sv
module testbench import salc_pkg::*;;

  localparam int MAX_ROWS = 64;
  localparam int MAX_WAYS = 8;
  localparam int ROW_LOG2_LIMIT = $clog2(MAX_ROWS);
  localparam logic [1:0] OP_NO_EFFECT = 2'd3;
  localparam int PHASES = 11;
  localparam int ITEMS_PER_PHASE = 48;
  localparam int SETTLE_CYCLES = 80;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int HOLD_OFF_AFTER = 150;
  localparam int WATCHDOG_LIMIT = 2000;

  class lru_tag_tracker;
    bit entry_valid [MAX_ROWS][MAX_WAYS];
    bit [ADDR_W-1:0] entry_tag [MAX_ROWS][MAX_WAYS];
    bit [TOTAL_W-1:0] total;
    bit [2:0] block_log2;
    bit [2:0] row_log2;
    bit [3:0] ways_in_use;
    bit [7:0] miss_penalty;
    rsp_t expected_rsp [$];
    int errors;

    function new();
      total = '0;
      errors = 0;
      block_log2 = BLOCK_LOG2_RESET;
      row_log2 = ROW_LOG2_RESET;
      ways_in_use = WAYS_IN_USE_RESET;
      miss_penalty = MISS_PENALTY_RESET;
      foreach (entry_valid[i, j]) entry_valid[i][j] = 1'b0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_BLOCK_LOG2: block_log2 = value[2:0];
        REG_ROW_LOG2: row_log2 = value[2:0];
        REG_WAYS_IN_USE: ways_in_use = value[3:0];
        REG_MISS_PENALTY: miss_penalty = value[7:0];
        default: ;
      endcase
    endfunction

    function void promote(int row, int pos);
      bit v;
      bit [ADDR_W-1:0] t;
      v = entry_valid[row][pos];
      t = entry_tag[row][pos];
      for (int i = pos; i > 0; i--) begin
        entry_valid[row][i] = entry_valid[row][i-1];
        entry_tag[row][i] = entry_tag[row][i-1];
      end
      entry_valid[row][0] = v;
      entry_tag[row][0] = t;
    endfunction

    function void note_request(req_t r);
      rsp_t e;
      int bl, rl, nw, row, found;
      bit [ADDR_W-1:0] t;
      bit [TOTAL_W-1:0] cost;
      e = '0;
      case (r.opcode)
        OP_ACCESS: begin
          bl = int'(block_log2);
          if (bl < int'(BLOCK_LOG2_MIN)) bl = int'(BLOCK_LOG2_MIN);
          if (bl > int'(BLOCK_LOG2_MAX)) bl = int'(BLOCK_LOG2_MAX);
          rl = int'(row_log2);
          if (rl > ROW_LOG2_LIMIT) rl = ROW_LOG2_LIMIT;
          nw = int'(ways_in_use);
          if (nw < 1) nw = 1;
          if (nw > MAX_WAYS) nw = MAX_WAYS;
          row = (r.address >> bl) & ((1 << rl) - 1);
          t = r.address >> (bl + rl);
          found = -1;
          for (int i = 0; i < nw; i++) begin
            if (found < 0 && entry_valid[row][i] && entry_tag[row][i] == t) found = i;
          end
          if (found >= 0) begin
            promote(row, found);
            cost = 1;
            e.hit = 1'b1;
          end else begin
            entry_valid[row][nw-1] = 1'b1;
            entry_tag[row][nw-1] = t;
            promote(row, nw - 1);
            cost = 1 + miss_penalty + (1 << bl);
          end
          if (total > 32'hFFFF_FFFF - cost) total = 32'hFFFF_FFFF;
          else total = total + cost;
          e.row_index = ROW_OUT_W'(row);
          e.tag_value = t;
          e.access_cycles = COST_W'(cost);
        end
        OP_INVALIDATE: begin
          foreach (entry_valid[i, j]) entry_valid[i][j] = 1'b0;
        end
        OP_CLEAR_TOTAL: total = '0;
        default: ;
      endcase
      e.cycle_total = total;
      expected_rsp.push_back(e);
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_response(rsp_t got);
      rsp_t e;
      if (expected_rsp.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %p", $time, got);
        errors++;
        return;
      end
      e = expected_rsp.pop_front();
      compare_field("hit", e.hit, got.hit);
      compare_field("row_index", e.row_index, got.row_index);
      compare_field("tag_value", e.tag_value, got.tag_value);
      compare_field("access_cycles", e.access_cycles, got.access_cycles);
      compare_field("cycle_total", e.cycle_total, got.cycle_total);
    endfunction

    function int pending();
      return expected_rsp.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  lru_tag_tracker board;
  int req_count = 0;
  int burst_left = 0;
  int stall_cycles = 0;

  set_assoc_lru_cache_tags_core dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && rsp_ready) board.check_response(rsp);
      if (req_valid && req_ready) begin
        board.note_request(req);
        req_count++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    board.set_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic configure(input int bl, input int rl, input int nw, input int pen);
    write_reg(REG_BLOCK_LOG2, bl);
    write_reg(REG_ROW_LOG2, rl);
    write_reg(REG_WAYS_IN_USE, nw);
    write_reg(REG_MISS_PENALTY, pen);
  endtask

  task automatic offer(input req_t r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : receiver
    int len, mode;
    bit held;
    held = 1'b0;
    @(posedge clk);
    forever begin
      if (!held && req_count >= HOLD_OFF_AFTER) begin
        held = 1'b1;
        rsp_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      len = $urandom_range(4, 40);
      repeat (len) begin
        case (mode)
          0: rsp_ready <= 1'b1;
          1: rsp_ready <= 1'($urandom_range(0, 1));
          2: rsp_ready <= ($urandom_range(0, 3) == 0);
          default: rsp_ready <= ($urandom_range(0, 7) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    bit [ADDR_W-1:0] pool [16];
    bit [ADDR_W-1:0] shared_low;
    bit conflict;
    int pool_n, kind;
    req_t r;
    board = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    offer({OP_ACCESS, 16'h0000});
    offer({OP_ACCESS, 16'h0003});
    offer({OP_ACCESS, 16'hFFFF});
    offer({OP_ACCESS, 16'h0001});
    offer({OP_ACCESS, 16'h8000});
    offer({OP_ACCESS, 16'hFFFC});
    offer({OP_ACCESS, 16'h8002});
    offer({OP_NO_EFFECT, 16'hFFFF});
    offer({OP_CLEAR_TOTAL, 16'h5555});
    offer({OP_ACCESS, 16'hAAAA});
    offer({OP_INVALIDATE, 16'h0000});
    offer({OP_ACCESS, 16'h8000});
    offer({OP_ACCESS, 16'h5555});
    offer({OP_CLEAR_TOTAL, 16'hAAAA});
    drain();

    for (int p = 1; p <= PHASES; p++) begin
      case (p)
        1: configure(0, 7, 0, 0);
        2: configure(7, 0, 15, 255);
        3: configure(6, 6, 8, 255);
        4: configure(2, 1, 3, $urandom_range(0, 255));
        default: configure($urandom_range(0, 7), $urandom_range(0, 7),
                           $urandom_range(0, 15), $urandom_range(0, 255));
      endcase
      // Each phase may crowd the working set into one row to exercise replacement order.
      pool_n = $urandom_range(2, 16);
      shared_low = ADDR_W'($urandom);
      conflict = 1'($urandom_range(0, 1));
      for (int i = 0; i < pool_n; i++) begin
        pool[i] = ADDR_W'($urandom);
        if (conflict) pool[i][11:0] = shared_low[11:0];
      end
      repeat (ITEMS_PER_PHASE) begin
        kind = $urandom_range(0, 99);
        r.opcode = OP_ACCESS;
        r.address = ADDR_W'($urandom);
        if (kind < 3) r.opcode = OP_INVALIDATE;
        else if (kind < 6) r.opcode = OP_CLEAR_TOTAL;
        else if (kind < 8) r.opcode = OP_NO_EFFECT;
        else if (kind < 88) begin
          r.address = pool[$urandom_range(0, pool_n - 1)] ^ ADDR_W'($urandom_range(0, 3));
        end
        offer(r);
      end
      drain();
    end

    if (board.errors == 0 && board.pending() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end
endmodule
